// ===== hdl/kwm_pkg.sv =====
// kwm_pkg: shared types and constants for the k-way timestamp merge.
// No dependencies; imported by kwm_min_tree and kway_timestamp_merge_top.
package kwm_pkg;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int LIST_W    = 3;
  localparam int STAMP_W   = 64;
  localparam int REF_W     = 32;
  localparam int REC_W     = STAMP_W + REF_W;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS      = LIST_W + STAMP_W + REF_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = STAMP_W + REF_W + LIST_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_DELIVERED = 2'd1,
    STATUS_REFUSED   = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

endpackage

// ===== hdl/kwm_min_tree.sv =====
// kwm_min_tree: registered comparison tree picking the smallest valid stamp.
// One register level per tree level; depends on kwm_pkg.
module kwm_min_tree #(
  parameter int NUM_LEAVES = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [NUM_LEAVES-1:0]                  leaf_valid_i,
  input  logic [kwm_pkg::STAMP_W-1:0]            leaf_stamp_i [NUM_LEAVES],
  output logic                                   root_valid_o,
  output logic [$clog2(NUM_LEAVES)-1:0]          root_idx_o,
  output logic [kwm_pkg::STAMP_W-1:0]            root_stamp_o
);
  import kwm_pkg::*;

  localparam int LW = $clog2(NUM_LEAVES);
  localparam int P  = 1 << LW;

  // heap layout: node 1 is the root, children of n are 2n and 2n+1
  logic               node_v_q [1:P-1];
  logic [STAMP_W-1:0] node_s_q [1:P-1];
  logic [LW-1:0]      node_i_q [1:P-1];

  for (genvar n = 1; n < P; n++) begin : g_node
    logic               lv, rv, take_left;
    logic [STAMP_W-1:0] ls, rs;
    logic [LW-1:0]      li, ri;

    if (2 * n >= P) begin : g_leaf
      localparam int LI = 2 * n - P;
      localparam int RI = 2 * n + 1 - P;
      if (LI < NUM_LEAVES) begin : g_l
        assign lv = leaf_valid_i[LI];
        assign ls = leaf_stamp_i[LI];
      end else begin : g_l_pad
        assign lv = 1'b0;
        assign ls = '0;
      end
      if (RI < NUM_LEAVES) begin : g_r
        assign rv = leaf_valid_i[RI];
        assign rs = leaf_stamp_i[RI];
      end else begin : g_r_pad
        assign rv = 1'b0;
        assign rs = '0;
      end
      assign li = LW'(LI);
      assign ri = LW'(RI);
    end else begin : g_inner
      assign lv = node_v_q[2*n];
      assign ls = node_s_q[2*n];
      assign li = node_i_q[2*n];
      assign rv = node_v_q[2*n+1];
      assign rs = node_s_q[2*n+1];
      assign ri = node_i_q[2*n+1];
    end

    // left side holds the lower list indices, so it wins ties
    assign take_left = lv && (!rv || (ls <= rs));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        node_v_q[n] <= 1'b0;
      end else begin
        node_v_q[n] <= lv || rv;
      end
    end

    always_ff @(posedge clk_i) begin
      node_s_q[n] <= take_left ? ls : rs;
      node_i_q[n] <= take_left ? li : ri;
    end
  end

  assign root_valid_o = node_v_q[1];
  assign root_idx_o   = node_i_q[1];
  assign root_stamp_o = node_s_q[1];

endmodule

// ===== hdl/kway_timestamp_merge_top.sv =====
// kway_timestamp_merge_top: k-way merge of per-source record lists by timestamp.
// Depends on kwm_pkg and kwm_min_tree.
//
// Merges NUM_LISTS FIFO lists of (stamp, ref) records into one stream in
// ascending stamp order, lowest list index winning ties. Each command
// transfer (append, pop, clear) yields exactly one result transfer. The
// result register holds one result; a new command is taken no earlier than
// the cycle in which the held result is taken on the result side.
// Records live in one NUM_LISTS*LIST_DEPTH x 96 memory; the head record of
// every non-empty list is cached in flops and fed to a registered min tree
// of log2(NUM_LISTS) levels. With the result side ready, the commands run as
// follows:
//   - refused append, append to a non-empty list, pop with nothing left,
//     unused op: no wait for the tree.
//   - append to an empty list, clear: the tree settles on the new head cache
//     before the next command is taken.
//   - pop: when the list still holds records, a registered memory read
//     refills the head cache and then the tree settles; when the pop empties
//     that list, only the tree settles.
// No clearing pass is needed after reset: the memory is only read at
// occupied slots.
module kway_timestamp_merge_top #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] list_index, [66:3] stamp, [98:67] record_ref, [103:99] zero
  input  logic [kwm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [kwm_pkg::OP_W-1:0]          s_axis_tuser,
  // result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] out_stamp, [95:64] out_ref, [98:96] out_list, [103:99] zero
  output logic [kwm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [kwm_pkg::STATUS_W-1:0]      m_axis_tuser,
  // last
  output logic                              m_axis_tlast
);
  import kwm_pkg::*;

  localparam int LW      = $clog2(NUM_LISTS);
  localparam int PW      = $clog2(LIST_DEPTH) + 1;
  localparam int ENTRIES = NUM_LISTS * LIST_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int WW      = $clog2(LW + 1);

  localparam logic [PW-1:0] DEPTH_P  = PW'(LIST_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * LIST_DEPTH - 1);
  localparam logic [WW-1:0] SETTLE   = WW'(LW);

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } state_e;

  // pointers count modulo 2*LIST_DEPTH so full and empty differ
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] occupancy(input logic [PW-1:0] tail,
                                              input logic [PW-1:0] head);
    logic [PW:0] t;
    t = {1'b0, tail} - {1'b0, head};
    if (tail < head) begin
      t = t + (PW+1)'(2 * LIST_DEPTH);
    end
    return PW'(t);
  endfunction

  function automatic logic [AW-1:0] slot(input logic [LW-1:0] l,
                                         input logic [PW-1:0] p);
    logic [PW-1:0] off;
    off = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return AW'(l) * AW'(LIST_DEPTH) + AW'(off);
  endfunction

  // ---------------------------------------------------------------- state
  state_e              state_q;
  logic [WW-1:0]       wait_q;
  logic [LW-1:0]       refill_idx_q;
  logic [PW-1:0]       head_q [NUM_LISTS];
  logic [PW-1:0]       tail_q [NUM_LISTS];
  logic [CW-1:0]       total_q;
  logic [NUM_LISTS-1:0] hv_q;
  logic [STAMP_W-1:0]  hstamp_q [NUM_LISTS];
  logic [REF_W-1:0]    href_q [NUM_LISTS];

  logic [REC_W-1:0]    mem [ENTRIES];
  logic [REC_W-1:0]    rd_q;

  logic                m_valid_q;
  status_e             status_q;
  logic [STAMP_W-1:0]  ostamp_q;
  logic [REF_W-1:0]    oref_q;
  logic [LIST_W-1:0]   olist_q;
  logic                olast_q;

  // ---------------------------------------------------------------- decode
  op_e                 op_w;
  logic [LIST_W-1:0]   li_w;
  logic [STAMP_W-1:0]  stamp_w;
  logic [REF_W-1:0]    ref_w;
  logic [LW-1:0]       li_idx;
  logic                li_ok;
  logic [PW-1:0]       app_occ;
  logic                app_ok;
  logic                in_fire;

  logic                root_valid;
  logic [LW-1:0]       root_idx;
  logic [STAMP_W-1:0]  root_stamp;
  logic [PW-1:0]       win_occ;
  logic [PW-1:0]       win_next_head;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;

  status_e             status_d;
  logic                deliver_d;

  assign op_w    = op_e'(s_axis_tuser);
  assign li_w    = s_axis_tdata[LIST_W-1:0];
  assign stamp_w = s_axis_tdata[LIST_W +: STAMP_W];
  assign ref_w   = s_axis_tdata[LIST_W+STAMP_W +: REF_W];

  assign li_idx  = LW'(li_w);
  assign li_ok   = (32'(li_w) < NUM_LISTS);
  assign app_occ = occupancy(tail_q[li_idx], head_q[li_idx]);
  assign app_ok  = li_ok && (app_occ != DEPTH_P);

  assign s_axis_tready = (state_q == ST_IDLE) && (wait_q == '0) &&
                         (!m_valid_q || m_axis_tready);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign win_occ       = occupancy(tail_q[root_idx], head_q[root_idx]);
  assign win_next_head = ptr_inc(head_q[root_idx]);

  assign mem_we    = in_fire && (op_w == OP_APPEND) && app_ok;
  assign mem_waddr = slot(li_idx, tail_q[li_idx]);
  // next head of the winning list, fetched during the pop transfer
  assign mem_raddr = slot(root_idx, win_next_head);

  always_comb begin
    status_d  = STATUS_DONE;
    deliver_d = 1'b0;
    case (op_w)
      OP_APPEND: status_d = app_ok ? STATUS_DONE : STATUS_REFUSED;
      OP_POP: begin
        deliver_d = root_valid;
        status_d  = root_valid ? STATUS_DELIVERED : STATUS_EMPTY;
      end
      default: status_d = STATUS_DONE;
    endcase
  end

  // ---------------------------------------------------------------- min tree
  kwm_min_tree #(
    .NUM_LEAVES (NUM_LISTS)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .leaf_valid_i (hv_q),
    .leaf_stamp_i (hstamp_q),
    .root_valid_o (root_valid),
    .root_idx_o   (root_idx),
    .root_stamp_o (root_stamp)
  );

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {ref_w, stamp_w};
    end
    rd_q <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wait_q       <= '0;
      refill_idx_q <= '0;
      total_q      <= '0;
      hv_q         <= '0;
      m_valid_q    <= 1'b0;
      for (int l = 0; l < NUM_LISTS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready && !in_fire) begin
        m_valid_q <= 1'b0;
      end
      if (wait_q != '0) begin
        wait_q <= wait_q - WW'(1);
      end
      case (state_q)
        ST_REFILL: begin
          hv_q[refill_idx_q] <= 1'b1;
          wait_q             <= SETTLE;
          state_q            <= ST_IDLE;
        end
        default: begin
          if (in_fire) begin
            m_valid_q <= 1'b1;
            case (op_w)
              OP_APPEND: begin
                if (app_ok) begin
                  tail_q[li_idx] <= ptr_inc(tail_q[li_idx]);
                  total_q        <= total_q + CW'(1);
                  if (app_occ == '0) begin
                    hv_q[li_idx] <= 1'b1;
                    wait_q       <= SETTLE;
                  end
                end
              end
              OP_POP: begin
                if (root_valid) begin
                  head_q[root_idx] <= win_next_head;
                  total_q          <= total_q - CW'(1);
                  hv_q[root_idx]   <= 1'b0;
                  if (win_occ > PW'(1)) begin
                    state_q      <= ST_REFILL;
                    refill_idx_q <= root_idx;
                  end else begin
                    wait_q <= SETTLE;
                  end
                end
              end
              OP_CLEAR: begin
                for (int l = 0; l < NUM_LISTS; l++) begin
                  head_q[l] <= '0;
                  tail_q[l] <= '0;
                end
                hv_q    <= '0;
                total_q <= '0;
                wait_q  <= SETTLE;
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // head cache: loaded on append to an empty list or by a refill
  always_ff @(posedge clk_i) begin
    if (state_q == ST_REFILL) begin
      hstamp_q[refill_idx_q] <= rd_q[STAMP_W-1:0];
      href_q[refill_idx_q]   <= rd_q[REC_W-1:STAMP_W];
    end else if (mem_we && (app_occ == '0)) begin
      hstamp_q[li_idx] <= stamp_w;
      href_q[li_idx]   <= ref_w;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      ostamp_q <= deliver_d ? root_stamp : '0;
      oref_q   <= deliver_d ? href_q[root_idx] : '0;
      olist_q  <= deliver_d ? LIST_W'(root_idx) : '0;
      olast_q  <= deliver_d && (total_q == CW'(1));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, olist_q, oref_q, ostamp_q};

endmodule

// ===== sim/kway_timestamp_merge_top_tb.sv =====
// Self-checking testbench for kway_timestamp_merge_top: append, pop and clear traffic
// is checked against an in-bench merge predictor. Depends on kwm_pkg and the
// kway_timestamp_merge_top RTL.
module kway_timestamp_merge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;
  localparam int PTR_W      = $clog2(2 * LIST_DEPTH);   // wraps at 2*depth: full != empty
  localparam int SLOT_W     = PTR_W - 1;
  localparam int IN_PAD_W   = IN_TDATA_W - IN_BITS;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  // one command on the slave side
  typedef struct packed {
    op_e               op;
    logic [LIST_W-1:0]  list_idx;
    logic [STAMP_W-1:0] stamp;
    logic [REF_W-1:0]   rec_ref;
  } cmd_t;

  // one result on the master side
  typedef struct packed {
    status_e            status;
    logic [STAMP_W-1:0] stamp;
    logic [REF_W-1:0]   rec_ref;
    logic [LIST_W-1:0]  list_idx;
    logic               last;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [2:0] list_index, [66:3] stamp, [98:67] record_ref, [103:99] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [1:0] op
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [63:0] out_stamp, [95:64] out_ref, [98:96] out_list, [103:99] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;

  kway_timestamp_merge_top #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Merge predictor state: a private copy of the record lists
  // ---------------------------------------------------------------------------
  logic [STAMP_W-1:0] list_stamp [NUM_LISTS*LIST_DEPTH];
  logic [REF_W-1:0]   list_ref   [NUM_LISTS*LIST_DEPTH];
  logic [PTR_W-1:0]   head_ptr   [NUM_LISTS];
  logic [PTR_W-1:0]   tail_ptr   [NUM_LISTS];

  cmd_t    cmd_backlog[$];       // commands not yet offered to the block
  result_t awaited_results[$];   // predicted results, oldest first

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        took           = 1'b0;   // slave transfer at the last rising edge

  function automatic int unsigned list_fill(int l);
    logic [PTR_W-1:0] diff;
    diff = tail_ptr[l] - head_ptr[l];
    return 32'(diff);
  endfunction

  function automatic int slot_of(int l, logic [PTR_W-1:0] ptr);
    return l * LIST_DEPTH + int'(ptr[SLOT_W-1:0]);
  endfunction

  // Applies one command to the private lists and returns what the block must answer.
  function automatic result_t predict_merge(cmd_t c);
    result_t          r;
    int               win;
    int               slot;
    logic             found;
    logic             any_left;
    logic [STAMP_W-1:0] best;
    r.status   = STATUS_DONE;
    r.stamp    = '0;
    r.rec_ref  = '0;
    r.list_idx = '0;
    r.last     = 1'b0;
    win        = 0;
    found      = 1'b0;
    any_left   = 1'b0;
    best       = '0;
    case (c.op)
      OP_APPEND: begin
        if (int'(c.list_idx) >= NUM_LISTS || list_fill(c.list_idx) >= LIST_DEPTH) begin
          r.status = STATUS_REFUSED;
        end else begin
          slot = slot_of(c.list_idx, tail_ptr[c.list_idx]);
          list_stamp[slot] = c.stamp;
          list_ref[slot]   = c.rec_ref;
          tail_ptr[c.list_idx] = tail_ptr[c.list_idx] + 1'b1;
        end
      end
      OP_POP: begin
        // strict less-than keeps the lowest index on ties
        for (int l = 0; l < NUM_LISTS; l++) begin
          if (list_fill(l) != 0) begin
            slot = slot_of(l, head_ptr[l]);
            if (!found || list_stamp[slot] < best) begin
              found = 1'b1;
              best  = list_stamp[slot];
              win   = l;
            end
          end
        end
        if (!found) begin
          r.status = STATUS_EMPTY;
        end else begin
          slot = slot_of(win, head_ptr[win]);
          head_ptr[win] = head_ptr[win] + 1'b1;
          for (int l = 0; l < NUM_LISTS; l++) begin
            if (list_fill(l) != 0) any_left = 1'b1;
          end
          r.status   = STATUS_DELIVERED;
          r.stamp    = list_stamp[slot];
          r.rec_ref  = list_ref[slot];
          r.list_idx = LIST_W'(win);
          r.last     = !any_left;
        end
      end
      OP_CLEAR: begin
        for (int l = 0; l < NUM_LISTS; l++) begin
          head_ptr[l] = '0;
          tail_ptr[l] = '0;
        end
      end
      default: ;   // unused op: no state change, plain done
    endcase
    return r;
  endfunction

  function automatic logic chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers backlog commands at the falling edge, holds them until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    cmd_t c;
    if (rst_ni) begin
      if (!s_axis_tvalid || took) begin
        if (cmd_backlog.size() != 0 && !chance(send_idle_pct)) begin
          c = cmd_backlog.pop_front();
          s_axis_tdata  <= {{IN_PAD_W{1'b0}}, c.rec_ref, c.stamp, c.list_idx};
          s_axis_tuser  <= c.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !chance(recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each slave transfer, checks each master transfer.
  // The prediction is queued first so a same-edge result still finds it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    cmd_t    c;
    result_t want;
    if (rst_ni) begin
      took <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        c.op       = op_e'(s_axis_tuser);
        c.list_idx = s_axis_tdata[0 +: LIST_W];
        c.stamp    = s_axis_tdata[LIST_W +: STAMP_W];
        c.rec_ref  = s_axis_tdata[LIST_W+STAMP_W +: REF_W];
        want = predict_merge(c);
        awaited_results = {awaited_results, want};
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing pending: status %0d", m_axis_tuser);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: exp %0d got %0d", want.status, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata[0 +: STAMP_W] !== want.stamp) begin
            $error("out_stamp: exp %h got %h", want.stamp, m_axis_tdata[0 +: STAMP_W]);
            error_count++;
          end
          if (m_axis_tdata[STAMP_W +: REF_W] !== want.rec_ref) begin
            $error("out_ref: exp %h got %h", want.rec_ref, m_axis_tdata[STAMP_W +: REF_W]);
            error_count++;
          end
          if (m_axis_tdata[STAMP_W+REF_W +: LIST_W] !== want.list_idx) begin
            $error("out_list: exp %0d got %0d", want.list_idx,
                   m_axis_tdata[STAMP_W+REF_W +: LIST_W]);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: exp %0b got %0b", want.last, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tdata[OUT_BITS +: OUT_PAD_W] !== '0) begin
            $error("tdata pad: exp 0 got %h", m_axis_tdata[OUT_BITS +: OUT_PAD_W]);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(op_e op, logic [LIST_W-1:0] li, logic [STAMP_W-1:0] st,
                           logic [REF_W-1:0] rr);
    cmd_t c;
    c.op       = op;
    c.list_idx = li;
    c.stamp    = st;
    c.rec_ref  = rr;
    cmd_backlog = {cmd_backlog, c};
    queued_count++;
  endtask

  function automatic logic [STAMP_W-1:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [STAMP_W-1:0] edge_stamp();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 64'd1;
      2:       return STAMP_MAX - 1'b1;
      default: return STAMP_MAX;
    endcase
  endfunction

  // wait until every queued command went through and every result came back
  task automatic wait_drained();
    while (accepted_count != queued_count || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  // clear, fill one list past full, then drain it plus one pop on empty
  task automatic fill_and_drain(logic [LIST_W-1:0] li);
    queue_cmd(OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < LIST_DEPTH + 2; i++)
      queue_cmd(OP_APPEND, li, wide_rand(), $urandom);
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      queue_cmd(OP_POP, li, wide_rand(), $urandom);
  endtask

  // Mostly append bursts followed by pops that drain the merge,
  // with some raw noise, clears and the odd full-list run.
  task automatic queue_traffic(int unsigned budget);
    int unsigned      used;
    int unsigned      kind;
    int unsigned      n;
    int unsigned      mode;
    int unsigned      list_span;
    int unsigned      extra;
    logic [LIST_W-1:0]  li;
    logic [STAMP_W-1:0] st;
    logic [STAMP_W-1:0] run_stamp [NUM_LISTS];
    op_e              op;
    used = 0;
    while (used < budget) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n         = $urandom_range(1, 24);
        mode      = $urandom_range(3);
        list_span = $urandom_range(1, NUM_LISTS - 1);   // few lists give deep runs
        st        = wide_rand();
        if (mode == 1 && $urandom_range(1)) st = '0;
        for (int l = 0; l < NUM_LISTS; l++) run_stamp[l] = st;
        for (int i = 0; i < n; i++) begin
          li = LIST_W'($urandom_range(list_span));
          if ($urandom_range(3) == 0) li = LIST_W'($urandom_range(NUM_LISTS - 1));
          case (mode)
            0: st = STAMP_W'($urandom_range(7));            // heavy ties
            1: begin                                       // each list in order
              run_stamp[li] = run_stamp[li] + STAMP_W'($urandom_range(3));
              st = run_stamp[li];
            end
            2: st = wide_rand();
            default: st = edge_stamp();
          endcase
          queue_cmd(OP_APPEND, li, st, $urandom);
        end
        // usually drain fully and probe empty, sometimes leave records behind
        extra = $urandom_range(9) == 0 ? 0 : $urandom_range(0, 2);
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        for (int i = 0; i < n + extra; i++)
          queue_cmd(OP_POP, LIST_W'($urandom), wide_rand(), $urandom);
        used += 2 * n + extra;
      end else if (kind < 73) begin
        fill_and_drain(LIST_W'($urandom_range(NUM_LISTS - 1)));
        used += 2 * LIST_DEPTH + 4;
      end else begin
        op = op_e'($urandom_range(3));
        queue_cmd(op, LIST_W'($urandom), wide_rand(), $urandom);
        if (op != OP_NONE) used++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      head_ptr[l] = '0;
      tail_ptr[l] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pop, unused op, clear on empty, extremes and ties
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_NONE,   3'd7, STAMP_MAX, 32'hFFFF_FFFF);
    queue_cmd(OP_CLEAR,  3'd5, STAMP_MAX, 32'hFFFF_FFFF);
    queue_cmd(OP_APPEND, 3'd0, STAMP_MAX, 32'hFFFF_FFFF);
    queue_cmd(OP_APPEND, 3'd7, '0, '0);
    queue_cmd(OP_APPEND, 3'd3, '0, 32'h5A5A_5A5A);       // tie with list 7
    queue_cmd(OP_APPEND, 3'd5, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5);
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_POP,    3'd0, '0, '0);                  // drains everything: last
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_APPEND, 3'd1, 64'd10, 32'h1);
    queue_cmd(OP_APPEND, 3'd1, 64'd5, 32'h2);            // head stays at 10
    queue_cmd(OP_APPEND, 3'd2, 64'd10, 32'h3);
    queue_cmd(OP_APPEND, 3'd6, 64'd11, 32'h4);
    queue_cmd(OP_POP,    3'd7, STAMP_MAX, 32'hFFFF_FFFF);
    queue_cmd(OP_NONE,   3'd2, 64'h0123_4567_89AB_CDEF, 32'h8000_0001);
    queue_cmd(OP_CLEAR,  3'd0, '0, '0);                  // drops pending records
    queue_cmd(OP_POP,    3'd0, '0, '0);
    queue_cmd(OP_APPEND, 3'd4, 64'd3, 32'h0000_FFFF);
    queue_cmd(OP_POP,    3'd0, '0, '0);
    wait_drained();

    // no idling, one full list up front
    fill_and_drain(3'd2);
    queue_traffic(235);
    wait_drained();

    send_idle_pct = 68;
    recv_stall_pct = 0;
    queue_traffic(235);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 68;
    queue_traffic(235);
    wait_drained();

    send_idle_pct = 6;
    recv_stall_pct = 6;
    queue_traffic(235);
    wait_drained();

    // let any stray result surface
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== kway_timestamp_merge_top.f =====
hdl/kwm_pkg.sv
hdl/kwm_min_tree.sv
hdl/kway_timestamp_merge_top.sv
sim/kway_timestamp_merge_top_tb.sv
